[src/mqfd_pkg.sv]
// ----------------------------------------------------------------------------
// mqfd_pkg
// shared types and constants of the message queue filter dispatch block
// ----------------------------------------------------------------------------
package mqfd_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_SUBS    = 16;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int SW          = $clog2(MAX_SUBS);
  localparam int CMD_DEPTH   = 2;

  typedef enum logic [1:0] {
    MODE_SUB   = 2'd0,
    MODE_UNSUB = 2'd1,
    MODE_PUB   = 2'd2,
    MODE_PROC  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // command from front to back part
  typedef struct packed {
    logic          is_proc;    // process with a queued message
    logic [1:0]    status;
    logic [4:0]    sub_id;
    logic          drop;
    logic          sent;
    logic [QW-1:0] head;
  } cmd_t;

endpackage

[src/mqfd_front.sv]
// ----------------------------------------------------------------------------
// mqfd_front
// accepts items, keeps subscriber table, queue pointers and message store
// ----------------------------------------------------------------------------
module mqfd_front
  import mqfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [15:0]         topic,
  input  logic [31:0]         unsub_id,
  input  logic [31:0]         sender,
  input  logic [31:0]         target,
  input  logic                broadcast,
  input  logic [63:0]         time_stamp,
  input  logic [31:0]         payload_word,
  output cmd_t                cmd,
  output logic                cmd_push,
  input  logic                cmd_full,
  input  logic                proc_done,
  input  logic [QW-1:0]       rd_addr,
  output logic [176:0]        rd_data,
  output logic [MAX_SUBS-1:0] active,
  output logic [15:0]         filt [MAX_SUBS],
  output logic [SW:0]         sub_total
);

  logic [176:0]  mem [QUEUE_DEPTH];
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [QW:0]   fill;
  logic          take;
  logic          proc_busy;
  mode_t         m;

  // hold off input while the command queue is full or a process reads the table and the store
  assign m    = mode_t'(mode);
  assign full = cmd_full || proc_busy;
  assign take = push && !full;

  always_comb begin
    cmd = '0;
    cmd.head = head;
    unique case (m)
      MODE_SUB: begin
        if (sub_total >= (SW+1)'(MAX_SUBS)) begin
          cmd.status = ST_OVERFLOW;
        end else begin
          cmd.sub_id = 5'(sub_total + 1'b1);
        end
      end
      MODE_UNSUB: begin
        if (!(unsub_id >= 32'd1 && unsub_id <= 32'(sub_total))) begin
          cmd.status = ST_NOT_FOUND;
        end
      end
      MODE_PUB: begin
        if (fill == (QW+1)'(QUEUE_DEPTH)) begin
          cmd.status = ST_OVERFLOW;
          cmd.drop   = 1'b1;
        end else begin
          cmd.sent = 1'b1;
        end
      end
      MODE_PROC: begin
        if (fill == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.is_proc = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign cmd_push = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      active    <= '0;
      sub_total <= '0;
      proc_busy <= 1'b0;
    end else begin
      if (take && cmd.is_proc) proc_busy <= 1'b1;
      else if (proc_done) proc_busy <= 1'b0;
      if (take) begin
        if (m == MODE_SUB && !cmd.status[0]) begin
          active[sub_total[SW-1:0]] <= 1'b1;
          sub_total <= sub_total + 1'b1;
        end
        if (m == MODE_UNSUB && cmd.status == ST_OK) begin
          active[SW'(unsub_id - 32'd1)] <= 1'b0;
        end
        if (cmd.sent) begin
          tail <= (tail == QW'(QUEUE_DEPTH-1)) ? '0 : tail + 1'b1;
          fill <= fill + 1'b1;
        end
        if (cmd.is_proc) begin
          head <= (head == QW'(QUEUE_DEPTH-1)) ? '0 : head + 1'b1;
          fill <= fill - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && m == MODE_SUB && !cmd.status[0]) begin
      filt[sub_total[SW-1:0]] <= topic;
    end
  end

  // message store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (take && cmd.sent) begin
      mem[tail] <= {broadcast, topic, sender, target, time_stamp, payload_word};
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/mqfd_cmdq.sv]
// ----------------------------------------------------------------------------
// mqfd_cmdq
// short queue of classified commands between front and back
// ----------------------------------------------------------------------------
module mqfd_cmdq
  import mqfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  cmd_t       slots [CMD_DEPTH];
  logic [0:0] wp;
  logic [0:0] rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'(CMD_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wp] <= wdata;
  end

endmodule

[src/mqfd_back.sv]
// ----------------------------------------------------------------------------
// mqfd_back
// carries out commands, scans subscribers, keeps totals, holds result register
// ----------------------------------------------------------------------------
module mqfd_back
  import mqfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         local_id,
  input  cmd_t                cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                proc_done,
  output logic [QW-1:0]       rd_addr,
  input  logic [176:0]        rd_data,
  input  logic [MAX_SUBS-1:0] active,
  input  logic [15:0]         filt [MAX_SUBS],
  input  logic [SW:0]         sub_total,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status,
  output logic [4:0]          sub_id,
  output logic [15:0]         out_type,
  output logic [31:0]         out_src,
  output logic [31:0]         out_dst,
  output logic [63:0]         out_time,
  output logic [31:0]         out_payload,
  output logic                deliver_valid,
  output logic                last,
  output logic [63:0]         sent_total,
  output logic [63:0]         delivered_total,
  output logic [63:0]         dropped_total
);

  bk_state_t  state, state_next;
  logic [SW:0] idx;
  logic        any;
  logic        hit;
  logic        later;
  logic        dst_ok;
  logic        more;
  logic        load_plain;
  logic        load_scan;
  logic [MAX_SUBS-1:0] slot_hit;
  logic [63:0] sent_c, deliv_c, drop_c;
  logic        out_free;

  assign out_free = empty || pop;
  assign rd_addr  = cmd.head;
  assign dst_ok   = rd_data[176] || rd_data[127:96] == '0 || rd_data[127:96] == local_id;
  assign more     = (idx + 1'b1) < sub_total;

  // every subscriber slot that takes the message under dispatch
  always_comb begin
    for (int j = 0; j < MAX_SUBS; j++) begin
      slot_hit[j] = ((SW+1)'(j) < sub_total) && active[j] && dst_ok &&
                    (filt[j] == '0 || filt[j] == rd_data[175:160]);
    end
  end

  // another delivery still ahead of the scan position
  always_comb begin
    later = 1'b0;
    for (int j = 0; j < MAX_SUBS; j++) begin
      if ((SW+1)'(j) > idx) later = later | slot_hit[j];
    end
  end

  assign hit        = slot_hit[idx[SW-1:0]];
  assign load_plain = state == BK_IDLE && !cmd_empty && !cmd.is_proc && out_free;
  assign load_scan  = state == BK_SCAN && out_free && (hit || (!more && !any));
  assign proc_done  = state == BK_SCAN && out_free && !more;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!cmd_empty && cmd.is_proc) state_next = BK_READ;
      BK_READ: state_next = BK_SCAN;
      BK_SCAN: if (out_free && !more) state_next = BK_IDLE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    unique case (state)
      BK_IDLE: cmd_pop = !cmd_empty && !cmd.is_proc && out_free;
      BK_SCAN: cmd_pop = out_free && !more;
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      empty   <= 1'b1;
      idx     <= '0;
      any     <= 1'b0;
      sent_c  <= '0;
      deliv_c <= '0;
      drop_c  <= '0;
    end else begin
      state <= state_next;
      if (load_plain || load_scan) empty <= 1'b0;
      else if (pop) empty <= 1'b1;
      unique case (state)
        BK_IDLE: begin
          idx <= '0;
          any <= 1'b0;
          if (load_plain) begin
            if (cmd.sent) sent_c <= sent_c + 1'b1;
            if (cmd.drop) drop_c <= drop_c + 1'b1;
          end
        end
        BK_SCAN: begin
          if (out_free) begin
            idx <= idx + 1'b1;
            if (hit) begin
              any     <= 1'b1;
              deliv_c <= deliv_c + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    priority if (load_plain) begin
      status          <= cmd.status;
      sub_id          <= cmd.sub_id;
      {out_type, out_src, out_dst, out_time, out_payload} <= '0;
      deliver_valid   <= 1'b0;
      last            <= 1'b1;
      sent_total      <= sent_c + 64'(cmd.sent);
      delivered_total <= deliv_c;
      dropped_total   <= drop_c + 64'(cmd.drop);
    end else if (load_scan) begin
      status          <= ST_OK;
      sub_id          <= hit ? 5'(idx + 1'b1) : '0;
      out_type        <= hit ? rd_data[175:160] : '0;
      out_src         <= hit ? rd_data[159:128] : '0;
      out_dst         <= hit ? rd_data[127:96] : '0;
      out_time        <= hit ? rd_data[95:32] : '0;
      out_payload     <= hit ? rd_data[31:0] : '0;
      deliver_valid   <= hit;
      last            <= hit ? !later : 1'b1;
      sent_total      <= sent_c;
      delivered_total <= deliv_c + 64'(hit);
      dropped_total   <= drop_c;
    end
  end

endmodule

[src/message_queue_filter_dispatch_top.sv]
// ----------------------------------------------------------------------------
// message_queue_filter_dispatch_top
// publish/subscribe queue with type filtering and per-subscriber dispatch
// ----------------------------------------------------------------------------
// channel  | handshake        | payload
// input    | push / full      | mode topic unsub_id sender target ...
// result   | empty / pop      | status sub_id out_* deliver_valid last totals
// config   | cfg_we           | cfg_data (local agent id)
//
// subscribe, unsubscribe and publish: result via command queue, result register
// process: command queue, then states BK_READ (store read) and BK_SCAN,
// one subscriber slot per cycle while the result register is free
// full stays high from a process accept until its scan ends
// reset is synchronous; no clearing pass is needed
// a full result register stalls the subscriber scan until pop
// ----------------------------------------------------------------------------
module message_queue_filter_dispatch_top
  import mqfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [15:0] topic,
  input  logic [31:0] unsub_id,
  input  logic [31:0] sender,
  input  logic [31:0] target,
  input  logic        broadcast,
  input  logic [63:0] time_stamp,
  input  logic [31:0] payload_word,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [4:0]  sub_id,
  output logic [15:0] out_type,
  output logic [31:0] out_src,
  output logic [31:0] out_dst,
  output logic [63:0] out_time,
  output logic [31:0] out_payload,
  output logic        deliver_valid,
  output logic        last,
  output logic [63:0] sent_total,
  output logic [63:0] delivered_total,
  output logic [63:0] dropped_total
);

  logic [31:0]         local_id;
  cmd_t                f_cmd, b_cmd;
  logic                f_push, q_full, q_empty, b_pop;
  logic                proc_done;
  logic [QW-1:0]       rd_addr;
  logic [176:0]        rd_data;
  logic [MAX_SUBS-1:0] active;
  logic [15:0]         filt [MAX_SUBS];
  logic [SW:0]         sub_total;

  // local agent id register
  always_ff @(posedge clk) begin
    if (rst) local_id <= '0;
    else if (cfg_we) local_id <= cfg_data;
  end

  mqfd_front u_front (
    .clk, .rst, .push, .full, .mode, .topic, .unsub_id, .sender,
    .target, .broadcast, .time_stamp, .payload_word,
    .cmd(f_cmd), .cmd_push(f_push), .cmd_full(q_full), .proc_done,
    .rd_addr, .rd_data, .active, .filt, .sub_total
  );

  // command queue decouples classification from dispatch
  mqfd_cmdq u_cmdq (
    .clk, .rst, .push(f_push), .wdata(f_cmd), .full(q_full),
    .pop(b_pop), .rdata(b_cmd), .empty(q_empty)
  );

  mqfd_back u_back (
    .clk, .rst, .local_id, .cmd(b_cmd), .cmd_empty(q_empty), .cmd_pop(b_pop),
    .proc_done, .rd_addr, .rd_data, .active, .filt, .sub_total,
    .empty, .pop, .status, .sub_id, .out_type, .out_src, .out_dst, .out_time,
    .out_payload, .deliver_valid, .last, .sent_total, .delivered_total,
    .dropped_total
  );

endmodule

[src/mqfd_checker.sv]
// ----------------------------------------------------------------------------
// mqfd_checker
// port-level checks of the top level
// ----------------------------------------------------------------------------
module mqfd_checker
  import mqfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        deliver_valid,
  input logic        last,
  input logic [1:0]  status,
  input logic [4:0]  sub_id,
  input logic [63:0] sent_total
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(sub_id) && $stable(sent_total))
    else $error("result changed");

  a_deliv_ok: assert property (@(posedge clk) disable iff (rst)
    !empty && deliver_valid |-> status == ST_OK && sub_id != '0)
    else $error("bad delivery");

  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !deliver_valid |-> last) else $error("non delivery without last");

  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");

endmodule

bind message_queue_filter_dispatch_top mqfd_checker u_mqfd_checker (
  .clk, .rst, .empty, .pop, .deliver_valid, .last, .status, .sub_id, .sent_total
);

[verif/message_queue_filter_dispatch_top_test.sv]
// ----------------------------------------------------------------------------
// message_queue_filter_dispatch_top_test
// self-checking bench: a directed table then random traffic, every result
// compared field by field against a behavioral model of the subscriber table,
// the ring queue and the running totals; both sides idle at random
// ----------------------------------------------------------------------------
module message_queue_filter_dispatch_top_test;
  import mqfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // one input transaction
  typedef struct {
    mode_t       mode;
    logic [15:0] topic;
    logic [31:0] unsub_id;
    logic [31:0] sender;
    logic [31:0] target;
    logic        broadcast;
    logic [63:0] time_stamp;
    logic [31:0] payload_word;
  } msg_item_t;

  // one result transaction
  typedef struct {
    logic [1:0]  status;
    logic [4:0]  sub_id;
    logic [15:0] out_type;
    logic [31:0] out_src;
    logic [31:0] out_dst;
    logic [63:0] out_time;
    logic [31:0] out_payload;
    logic        deliver_valid;
    logic        last;
    logic [63:0] sent_total;
    logic [63:0] delivered_total;
    logic [63:0] dropped_total;
  } dispatch_t;

  // directed row: item, plus a status typed in where it is obvious
  typedef struct {
    msg_item_t   item;
    logic        check_status;
    status_t     want_status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = '0;
  logic [15:0] topic = '0;
  logic [31:0] unsub_id = '0;
  logic [31:0] sender = '0;
  logic [31:0] target = '0;
  logic        broadcast = 1'b0;
  logic [63:0] time_stamp = '0;
  logic [31:0] payload_word = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [4:0]  sub_id;
  logic [15:0] out_type;
  logic [31:0] out_src;
  logic [31:0] out_dst;
  logic [63:0] out_time;
  logic [31:0] out_payload;
  logic        deliver_valid;
  logic        last;
  logic [63:0] sent_total;
  logic [63:0] delivered_total;
  logic [63:0] dropped_total;

  message_queue_filter_dispatch_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .mode(mode), .topic(topic),
    .unsub_id(unsub_id), .sender(sender), .target(target),
    .broadcast(broadcast), .time_stamp(time_stamp), .payload_word(payload_word),
    .empty(empty), .pop(pop), .status(status), .sub_id(sub_id),
    .out_type(out_type), .out_src(out_src), .out_dst(out_dst),
    .out_time(out_time), .out_payload(out_payload),
    .deliver_valid(deliver_valid), .last(last), .sent_total(sent_total),
    .delivered_total(delivered_total), .dropped_total(dropped_total)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // model state of the block
  logic [15:0] sub_filter [MAX_SUBS];
  logic        sub_active [MAX_SUBS];
  int          sub_count;
  msg_item_t   msg_ring [$];
  logic [31:0] agent_id;
  logic [63:0] sent_cnt, delivered_cnt, dropped_cnt;

  dispatch_t   dispatch_expected [$];
  logic        status_pinned [$];   // directed status expected per transaction
  status_t     status_pinned_val [$];
  int          failures = 0;
  int          idle_cycles = 0;

  function automatic dispatch_t plain_result(logic [1:0] st, logic [4:0] id);
    dispatch_t r;
    r = '{default: '0};
    r.status = st;
    r.sub_id = id;
    r.last = 1'b1;
    r.sent_total = sent_cnt;
    r.delivered_total = delivered_cnt;
    r.dropped_total = dropped_cnt;
    return r;
  endfunction

  // apply one accepted transaction to the model and queue its results
  task automatic predict_dispatch(msg_item_t it);
    dispatch_t r;
    msg_item_t m;
    logic      dst_ok;
    int        n;
    n = 0;
    case (it.mode)
      MODE_SUB: begin
        if (sub_count >= MAX_SUBS) begin
          dispatch_expected.push_back(plain_result(ST_OVERFLOW, 5'd0));
        end else begin
          sub_filter[sub_count] = it.topic;
          sub_active[sub_count] = 1'b1;
          sub_count++;
          dispatch_expected.push_back(plain_result(ST_OK, sub_count[4:0]));
        end
      end
      MODE_UNSUB: begin
        if (it.unsub_id >= 1 && it.unsub_id <= sub_count) begin
          sub_active[it.unsub_id - 1] = 1'b0;
          dispatch_expected.push_back(plain_result(ST_OK, 5'd0));
        end else begin
          dispatch_expected.push_back(plain_result(ST_NOT_FOUND, 5'd0));
        end
      end
      MODE_PUB: begin
        if (msg_ring.size() >= QUEUE_DEPTH) begin
          dropped_cnt++;
          dispatch_expected.push_back(plain_result(ST_OVERFLOW, 5'd0));
        end else begin
          msg_ring.push_back(it);
          sent_cnt++;
          dispatch_expected.push_back(plain_result(ST_OK, 5'd0));
        end
      end
      default: begin
        if (msg_ring.size() == 0) begin
          dispatch_expected.push_back(plain_result(ST_EMPTY, 5'd0));
        end else begin
          m = msg_ring.pop_front();
          dst_ok = m.broadcast || m.target == 0 || m.target == agent_id;
          for (int i = 0; i < sub_count; i++) begin
            if (sub_active[i] && dst_ok &&
                (sub_filter[i] == 0 || sub_filter[i] == m.topic)) begin
              delivered_cnt++;
              r = plain_result(ST_OK, 5'(i + 1));
              r.out_type = m.topic;
              r.out_src = m.sender;
              r.out_dst = m.target;
              r.out_time = m.time_stamp;
              r.out_payload = m.payload_word;
              r.deliver_valid = 1'b1;
              r.last = 1'b0;
              dispatch_expected.push_back(r);
              n++;
            end
          end
          if (n == 0) dispatch_expected.push_back(plain_result(ST_OK, 5'd0));
          else dispatch_expected[$].last = 1'b1;
        end
      end
    endcase
  endtask

  function automatic msg_item_t make_item(mode_t md, logic [15:0] ty, logic [31:0] uid,
                                          logic [31:0] dst, int bc);
    msg_item_t it;
    it.mode = md;
    it.topic = ty;
    it.unsub_id = uid;
    it.sender = $urandom;
    it.target = dst;
    it.broadcast = bc[0];
    it.time_stamp = {$urandom, $urandom};
    it.payload_word = $urandom;
    return it;
  endfunction

  // drive one transaction after a random gap, wait for acceptance
  task automatic send_item(msg_item_t it, logic pin, status_t st);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= it.mode;
    topic <= it.topic;
    unsub_id <= it.unsub_id;
    sender <= it.sender;
    target <= it.target;
    broadcast <= it.broadcast;
    time_stamp <= it.time_stamp;
    payload_word <= it.payload_word;
    do @(posedge clk); while (full);
    // the pinned status applies to the last result of this transaction
    status_pinned.push_back(pin);
    status_pinned_val.push_back(st);
    predict_dispatch(it);
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic wait_idle();
    push <= 1'b0;
    while (dispatch_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_agent(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    agent_id = v;
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int        stall;
    dispatch_t e, a;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      a.status = status; a.sub_id = sub_id; a.out_type = out_type;
      a.out_src = out_src; a.out_dst = out_dst; a.out_time = out_time;
      a.out_payload = out_payload; a.deliver_valid = deliver_valid; a.last = last;
      a.sent_total = sent_total; a.delivered_total = delivered_total;
      a.dropped_total = dropped_total;
      if (dispatch_expected.size() == 0) begin
        $error("result with nothing expected: status %0d sub_id %0d", a.status, a.sub_id);
        failures++;
        continue;
      end
      e = dispatch_expected.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); failures++; end
      if (a.sub_id !== e.sub_id) begin
        $error("sub_id exp %0d got %0d", e.sub_id, a.sub_id); failures++; end
      if (a.out_type !== e.out_type) begin
        $error("out_type exp %h got %h", e.out_type, a.out_type); failures++; end
      if (a.out_src !== e.out_src) begin
        $error("out_src exp %h got %h", e.out_src, a.out_src); failures++; end
      if (a.out_dst !== e.out_dst) begin
        $error("out_dst exp %h got %h", e.out_dst, a.out_dst); failures++; end
      if (a.out_time !== e.out_time) begin
        $error("out_time exp %h got %h", e.out_time, a.out_time); failures++; end
      if (a.out_payload !== e.out_payload) begin
        $error("out_payload exp %h got %h", e.out_payload, a.out_payload); failures++; end
      if (a.deliver_valid !== e.deliver_valid) begin
        $error("deliver_valid exp %0d got %0d", e.deliver_valid, a.deliver_valid);
        failures++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); failures++; end
      if (a.sent_total !== e.sent_total) begin
        $error("sent_total exp %0d got %0d", e.sent_total, a.sent_total); failures++; end
      if (a.delivered_total !== e.delivered_total) begin
        $error("delivered_total exp %0d got %0d", e.delivered_total, a.delivered_total);
        failures++;
      end
      if (a.dropped_total !== e.dropped_total) begin
        $error("dropped_total exp %0d got %0d", e.dropped_total, a.dropped_total);
        failures++;
      end
    end
  end

  // directed status check on the last result of each transaction
  initial begin
    forever begin
      @(posedge clk);
      if (pop && !empty && !rst) begin
        if (status_pinned.size() != 0 && (deliver_valid !== 1'b1 || last === 1'b1)) begin
          if (status_pinned[0] && status !== status_pinned_val[0]) begin
            $error("status exp %0d got %0d", status_pinned_val[0], status);
            failures++;
          end
        end
        if (last === 1'b1 && status_pinned.size() != 0) begin
          void'(status_pinned.pop_front());
          void'(status_pinned_val.pop_front());
        end
      end
    end
  end

  // watchdog: cycles without any accepted transaction on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t      directed_rows [$];
  initial begin
    msg_item_t it;
    int        r;
    logic [31:0] agents [4];
    agent_id = '0;
    sub_count = 0;
    sent_cnt = '0; delivered_cnt = '0; dropped_cnt = '0;
    for (int i = 0; i < MAX_SUBS; i++) begin
      sub_filter[i] = '0; sub_active[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty process, bad unsubscribes, extremes of the fields
    directed_rows = '{
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b1, ST_EMPTY},
      '{make_item(MODE_UNSUB, 16'h0, 32'h0, 32'h0, 0), 1'b1, ST_NOT_FOUND},
      '{make_item(MODE_UNSUB, 16'h0, 32'hFFFF_FFFF, 32'h0, 0), 1'b1, ST_NOT_FOUND},
      '{make_item(MODE_SUB, 16'h0, 32'h0, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_SUB, 16'hFFFF, 32'h0, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_SUB, 16'h0001, 32'h0, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_UNSUB, 16'h0, 32'd4, 32'h0, 0), 1'b1, ST_NOT_FOUND},
      '{make_item(MODE_PUB, 16'hFFFF, 32'h0, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_PUB, 16'h0001, 32'h0, 32'hFFFF_FFFF, 1), 1'b1, ST_OK},
      '{make_item(MODE_PUB, 16'h0001, 32'h0, 32'hFFFF_FFFF, 0), 1'b1, ST_OK},
      '{make_item(MODE_PUB, 16'h1234, 32'h0, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b0, ST_OK},
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b0, ST_OK},
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b0, ST_OK},
      '{make_item(MODE_UNSUB, 16'h0, 32'd1, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_UNSUB, 16'h0, 32'd1, 32'h0, 0), 1'b1, ST_OK},
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b0, ST_OK},
      '{make_item(MODE_PROC, 16'h0, 32'h0, 32'h0, 0), 1'b1, ST_EMPTY}
    };
    // extreme payload values on two messages
    directed_rows[8].item.sender = 32'hFFFF_FFFF;
    directed_rows[8].item.time_stamp = 64'hFFFF_FFFF_FFFF_FFFF;
    directed_rows[8].item.payload_word = 32'hFFFF_FFFF;
    directed_rows[7].item.sender = '0;
    directed_rows[7].item.time_stamp = '0;
    directed_rows[7].item.payload_word = '0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].check_status,
                directed_rows[i].want_status);
    wait_idle();

    // local id at the top extreme
    write_agent(32'hFFFF_FFFF);
    // fill the queue past its depth to hit the drop path
    for (int i = 0; i < QUEUE_DEPTH + 3; i++)
      send_item(make_item(MODE_PUB, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 0), 1'b0, ST_OK);
    wait_idle();

    // random phases with varied local id
    agents = '{32'h0, 32'h0000_00A5, 32'hFFFF_FFFF, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      write_agent(agents[ph]);
      for (int k = 0; k < 15; k++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          it = make_item(MODE_SUB, ($urandom_range(0, 2) == 0) ? 16'h0 :
                         16'($urandom_range(0, 3)), 32'h0, 32'h0, 0);
          if ($urandom_range(0, 7) == 0) it.topic = 16'($urandom);
        end else if (r < 3) begin
          it = make_item(MODE_UNSUB, 16'h0, ($urandom_range(0, 7) == 0) ? $urandom :
                         $urandom_range(0, 17), 32'h0, 0);
        end else if (r < 7) begin
          it = make_item(MODE_PUB, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 3)), $urandom,
                         ($urandom_range(0, 2) == 0) ? agents[ph] :
                         ($urandom_range(0, 1) ? 32'h0 : $urandom),
                         $urandom_range(0, 1));
          it.sender = $urandom;
        end else begin
          it = make_item(MODE_PROC, 16'($urandom), $urandom, $urandom,
                         $urandom_range(0, 1));
        end
        send_item(it, 1'b0, ST_OK);
      end
      wait_idle();
    end

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
